[hdl/wpse_pkg.sv]
// shared types and constants for the led pwm slot encoder
// no dependencies; used by every module of the block but wpse_ram, by scoped names

package wpse_pkg;

  // colour store geometry
  localparam int unsigned ADDR_W   = 8;
  localparam int unsigned MAX_LEDS = 1 << ADDR_W;
  localparam int unsigned COLOR_W  = 24;

  // register and counter widths
  localparam int unsigned LCNT_W   = 9;
  localparam int unsigned LATCH_W  = 4;
  localparam int unsigned CV_W     = 8;
  localparam int unsigned POS_W    = $clog2(MAX_LEDS + (1 << LATCH_W));
  localparam int unsigned STEP_W   = $clog2(POS_W);
  localparam int unsigned SLOTS    = COLOR_W;
  localparam int unsigned SLOT_W   = $clog2(SLOTS);

  // configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = LCNT_W;

  localparam logic [LCNT_W-1:0]  LED_COUNT_RST  = LCNT_W'(0);
  localparam logic [CV_W-1:0]    ONE_HIGH_RST   = CV_W'(58);
  localparam logic [CV_W-1:0]    ZERO_HIGH_RST  = CV_W'(29);
  localparam logic [LATCH_W-1:0] LATCH_GRP_RST  = LATCH_W'(5);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LED_COUNT = 2'd0,
    REG_ONE_HIGH  = 2'd1,
    REG_ZERO_HIGH = 2'd2,
    REG_LATCH_GRP = 2'd3
  } reg_idx_e;

  typedef enum logic {
    OP_WRITE    = 1'b0,
    OP_GENERATE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    FE_IDLE,
    FE_MOD,
    FE_READ,
    FE_PUSH
  } fe_state_e;

  // one group command from front to back
  typedef struct packed {
    logic               send;
    logic [COLOR_W-1:0] word;
  } cmd_t;

endpackage

[hdl/wpse_ram.sv]
// generic single write port ram with registered read
// no dependencies

module wpse_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/wpse_front.sv]
// front end: accepts write and generate transactions, keeps the colour store
// and the position counter; depends on wpse_pkg and wpse_ram

module wpse_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  logic                          operation_i,
  input  logic [wpse_pkg::ADDR_W-1:0]   led_index_i,
  input  logic [wpse_pkg::COLOR_W-1:0]  color_i,
  input  logic [wpse_pkg::LCNT_W-1:0]   led_count_i,
  input  logic [wpse_pkg::LATCH_W-1:0]  latch_groups_i,
  output wpse_pkg::cmd_t                cmd_o,
  output logic                          cmd_push_o,
  input  logic                          cmd_full_i
);

  wpse_pkg::fe_state_e state_q, state_d;
  logic [wpse_pkg::POS_W-1:0]    pos_q, pos_d;
  logic [wpse_pkg::POS_W-1:0]    div_q, div_d;
  logic [wpse_pkg::POS_W-1:0]    rem_q, rem_d;
  logic [wpse_pkg::STEP_W-1:0]   step_q, step_d;
  logic                          send_q, send_d;
  logic [wpse_pkg::MAX_LEDS-1:0] vld_q, vld_d;
  logic                          vld_rd_q, vld_rd_d;

  logic [wpse_pkg::LCNT_W-1:0]   leds;
  logic [wpse_pkg::POS_W-1:0]    period;
  logic [wpse_pkg::POS_W:0]      rem_sh;
  logic [wpse_pkg::POS_W:0]      rem_sub;
  logic                          accept;
  logic                          ram_we;
  logic                          ram_re;
  logic [wpse_pkg::ADDR_W-1:0]   ram_raddr;
  logic [wpse_pkg::COLOR_W-1:0]  ram_rdata;

  // led count saturated to the store depth
  assign leds = (led_count_i > wpse_pkg::LCNT_W'(wpse_pkg::MAX_LEDS))
              ? wpse_pkg::LCNT_W'(wpse_pkg::MAX_LEDS) : led_count_i;
  assign period = wpse_pkg::POS_W'(leds) + wpse_pkg::POS_W'(latch_groups_i);

  assign full   = (state_q != wpse_pkg::FE_IDLE);
  assign accept = push && !full;
  assign ram_we = accept && (operation_i == wpse_pkg::OP_WRITE);

  // one restoring remainder step per cycle
  assign rem_sh  = {rem_q, div_q[wpse_pkg::POS_W-1]};
  assign rem_sub = rem_sh - {1'b0, period};

  assign ram_raddr = rem_q[wpse_pkg::ADDR_W-1:0];

  wpse_ram #(
    .WIDTH (wpse_pkg::COLOR_W),
    .DEPTH (wpse_pkg::MAX_LEDS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (led_index_i),
    .wdata_i (color_i),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d    = state_q;
    pos_d      = pos_q;
    div_d      = div_q;
    rem_d      = rem_q;
    step_d     = step_q;
    send_d     = send_q;
    vld_d      = vld_q;
    vld_rd_d   = vld_rd_q;
    ram_re     = 1'b0;
    cmd_push_o = 1'b0;
    cmd_o.send = send_q;
    cmd_o.word = (send_q && vld_rd_q) ? ram_rdata : '0;

    case (state_q)
      wpse_pkg::FE_IDLE: begin
        if (accept) begin
          if (operation_i == wpse_pkg::OP_WRITE) begin
            vld_d[led_index_i] = 1'b1;
          end else if (period == '0) begin
            pos_d   = '0;
            send_d  = 1'b0;
            state_d = wpse_pkg::FE_PUSH;
          end else begin
            div_d   = pos_q;
            rem_d   = '0;
            step_d  = '0;
            state_d = wpse_pkg::FE_MOD;
          end
        end
      end
      wpse_pkg::FE_MOD: begin
        rem_d  = rem_sub[wpse_pkg::POS_W] ? rem_sh[wpse_pkg::POS_W-1:0]
                                          : rem_sub[wpse_pkg::POS_W-1:0];
        div_d  = div_q << 1;
        step_d = step_q + 1'b1;
        if (step_q == wpse_pkg::STEP_W'(wpse_pkg::POS_W - 1)) begin
          state_d = wpse_pkg::FE_READ;
        end
      end
      wpse_pkg::FE_READ: begin
        ram_re   = 1'b1;
        send_d   = (rem_q < wpse_pkg::POS_W'(leds));
        vld_rd_d = vld_q[ram_raddr];
        pos_d    = rem_q + 1'b1;
        state_d  = wpse_pkg::FE_PUSH;
      end
      wpse_pkg::FE_PUSH: begin
        if (!cmd_full_i) begin
          cmd_push_o = 1'b1;
          state_d    = wpse_pkg::FE_IDLE;
        end
      end
      default: begin
        state_d = wpse_pkg::FE_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wpse_pkg::FE_IDLE;
      pos_q   <= '0;
      vld_q   <= '0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      vld_q   <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    div_q    <= div_d;
    rem_q    <= rem_d;
    step_q   <= step_d;
    send_q   <= send_d;
    vld_rd_q <= vld_rd_d;
  end

endmodule

[hdl/wpse_queue.sv]
// two entry command queue between front and back end
// depends on wpse_pkg

module wpse_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  wpse_pkg::cmd_t wdata_i,
  output logic           full_o,
  input  logic           pop_i,
  output wpse_pkg::cmd_t rdata_o,
  output logic           empty_o
);

  wpse_pkg::cmd_t entry_q [2];
  logic           wptr_q, wptr_d;
  logic           rptr_q, rptr_d;
  logic [1:0]     cnt_q, cnt_d;
  logic           do_push;
  logic           do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = entry_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q + do_push;
    rptr_d = rptr_q + do_pop;
    cnt_d  = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wptr_q] <= wdata_i;
    end
  end

endmodule

[hdl/wpse_back.sv]
// back end: serializes one group command into 24 slot compare values
// depends on wpse_pkg

module wpse_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  wpse_pkg::cmd_t             cmd_i,
  input  logic                       cmd_empty_i,
  output logic                       cmd_pop_o,
  input  logic [wpse_pkg::CV_W-1:0]  one_high_i,
  input  logic [wpse_pkg::CV_W-1:0]  zero_high_i,
  output logic                       empty,
  input  logic                       pop,
  output logic [wpse_pkg::CV_W-1:0]  compare_value_o,
  output logic                       last_o
);

  logic                          busy_q, busy_d;
  logic                          send_q, send_d;
  logic [wpse_pkg::COLOR_W-1:0]  word_q, word_d;
  logic [wpse_pkg::SLOT_W-1:0]   slot_q, slot_d;
  logic                          ovld_q, ovld_d;
  logic [wpse_pkg::CV_W-1:0]     oval_q, oval_d;
  logic                          olast_q, olast_d;
  logic                          adv;
  logic                          final_slot;

  assign adv        = !ovld_q || pop;
  assign final_slot = (slot_q == wpse_pkg::SLOT_W'(wpse_pkg::SLOTS - 1));

  always_comb begin
    busy_d    = busy_q;
    send_d    = send_q;
    word_d    = word_q;
    slot_d    = slot_q;
    ovld_d    = ovld_q;
    oval_d    = oval_q;
    olast_d   = olast_q;
    cmd_pop_o = 1'b0;

    if (adv) begin
      ovld_d = busy_q;
      if (busy_q) begin
        oval_d  = !send_q ? '0
                : (word_q[wpse_pkg::COLOR_W-1] ? one_high_i : zero_high_i);
        olast_d = final_slot;
        word_d  = word_q << 1;
        slot_d  = slot_q + 1'b1;
        if (final_slot) begin
          busy_d = 1'b0;
        end
      end
    end

    if (!busy_q && !cmd_empty_i) begin
      cmd_pop_o = 1'b1;
      busy_d    = 1'b1;
      send_d    = cmd_i.send;
      word_d    = cmd_i.word;
      slot_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      ovld_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      ovld_q <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    send_q  <= send_d;
    word_q  <= word_d;
    slot_q  <= slot_d;
    oval_q  <= oval_d;
    olast_q <= olast_d;
  end

  assign empty           = !ovld_q;
  assign compare_value_o = oval_q;
  assign last_o          = olast_q;

endmodule

[hdl/ws2812_pwm_slot_encoder_top.sv]
// top level of the led pwm slot encoder: configuration registers and wiring
// depends on wpse_pkg, wpse_front, wpse_queue, wpse_back

// The encoder holds 256 colour words of 24 bits and a position counter that
// walks the led chain and then a run of latch groups. A write transaction
// (operation 0) stores one colour and yields nothing; it leaves the front end
// idle. A generate transaction (operation 1) yields 24 compare values, most
// significant colour bit first, with last set on the 24th; outside the chain
// the 24 values are zero and form the latch gap. For a generate transaction
// the front end folds the position back into the chain period in a 9 step
// remainder unit, reads the colour store once and pushes one queue entry,
// and takes no new transaction until that push; the back end emits one value
// per cycle while its output register is empty or popped. A two entry
// command queue and an output register let both sides stall independently.
// The colour store reads as zero until written; per entry valid flops clear
// at reset, so no clearing pass is needed. The user must write configuration
// through cfg_we_i, cfg_index_i, cfg_wdata_i only while the block is idle;
// the block itself does not enforce this.

module ws2812_pwm_slot_encoder_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // input transaction
  input  logic                            push,
  output logic                            full,
  input  logic                            operation_i,
  input  logic [wpse_pkg::ADDR_W-1:0]     led_index_i,
  input  logic [wpse_pkg::COLOR_W-1:0]    color_i,
  // result transaction
  output logic                            empty,
  input  logic                            pop,
  output logic [wpse_pkg::CV_W-1:0]       compare_value_o,
  output logic                            last_o,
  // configuration writes
  input  logic                            cfg_we_i,
  input  logic [wpse_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [wpse_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);

  logic [wpse_pkg::LCNT_W-1:0]  led_count_q, led_count_d;
  logic [wpse_pkg::CV_W-1:0]    one_high_q, one_high_d;
  logic [wpse_pkg::CV_W-1:0]    zero_high_q, zero_high_d;
  logic [wpse_pkg::LATCH_W-1:0] latch_grp_q, latch_grp_d;

  wpse_pkg::cmd_t fe_cmd;
  wpse_pkg::cmd_t q_cmd;
  logic           fe_push;
  logic           q_full;
  logic           q_empty;
  logic           be_pop;

  // register file writes
  always_comb begin
    led_count_d = led_count_q;
    one_high_d  = one_high_q;
    zero_high_d = zero_high_q;
    latch_grp_d = latch_grp_q;
    if (cfg_we_i) begin
      case (wpse_pkg::reg_idx_e'(cfg_index_i))
        wpse_pkg::REG_LED_COUNT: led_count_d = cfg_wdata_i;
        wpse_pkg::REG_ONE_HIGH:  one_high_d  = cfg_wdata_i[wpse_pkg::CV_W-1:0];
        wpse_pkg::REG_ZERO_HIGH: zero_high_d = cfg_wdata_i[wpse_pkg::CV_W-1:0];
        wpse_pkg::REG_LATCH_GRP: latch_grp_d = cfg_wdata_i[wpse_pkg::LATCH_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      led_count_q <= wpse_pkg::LED_COUNT_RST;
      one_high_q  <= wpse_pkg::ONE_HIGH_RST;
      zero_high_q <= wpse_pkg::ZERO_HIGH_RST;
      latch_grp_q <= wpse_pkg::LATCH_GRP_RST;
    end else begin
      led_count_q <= led_count_d;
      one_high_q  <= one_high_d;
      zero_high_q <= zero_high_d;
      latch_grp_q <= latch_grp_d;
    end
  end

  // front end: classify, store colours, fold position, fetch colour
  wpse_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .operation_i    (operation_i),
    .led_index_i    (led_index_i),
    .color_i        (color_i),
    .led_count_i    (led_count_q),
    .latch_groups_i (latch_grp_q),
    .cmd_o          (fe_cmd),
    .cmd_push_o     (fe_push),
    .cmd_full_i     (q_full)
  );

  // group commands waiting for the serializer
  wpse_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fe_push),
    .wdata_i (fe_cmd),
    .full_o  (q_full),
    .pop_i   (be_pop),
    .rdata_o (q_cmd),
    .empty_o (q_empty)
  );

  // back end: one slot value per cycle into the output register while it is empty or popped
  wpse_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (q_cmd),
    .cmd_empty_i     (q_empty),
    .cmd_pop_o       (be_pop),
    .one_high_i      (one_high_q),
    .zero_high_i     (zero_high_q),
    .empty           (empty),
    .pop             (pop),
    .compare_value_o (compare_value_o),
    .last_o          (last_o)
  );

endmodule
